// ===== sv/wma_pkg.sv =====
package wma_pkg;

    // Fixed field widths of the sample and result transactions
    localparam int SAMPLE_W = 32;
    localparam int AVG_W    = 32;
    localparam int HELD_W   = 7;

    // Quotient bits produced by the divider, one per step
    localparam int DIV_STEPS = AVG_W;

endpackage

// ===== sv/wma_front.sv =====
module wma_front #(
    parameter int WINDOW = 64,
    parameter int CW     = 7,
    parameter int AW     = 6,
    parameter int IW     = 46
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [wma_pkg::SAMPLE_W-1:0]    sample,
    input  logic                            q_full,
    output logic                            q_push,
    output logic [IW-1:0]                   q_data
);
    import wma_pkg::*;

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic          full_ring;
    logic [AW-1:0] slot;
    logic [CW-1:0] held;

    // Accept whenever the queue has room
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Classify: append while filling, overwrite the oldest once full
    always_comb
    begin
        full_ring = (fill_reg == CW'(WINDOW));
        fill_next = fill_reg;
        wp_next   = wp_reg;
        if (full_ring)
        begin
            slot = wp_reg;
            held = fill_reg;
            if (wp_reg == AW'(WINDOW - 1))
            begin
                wp_next = '0;
            end
            else
            begin
                wp_next = wp_reg + AW'(1);
            end
        end
        else
        begin
            slot      = fill_reg[AW-1:0];
            held      = fill_reg + CW'(1);
            fill_next = held;
        end
    end

    // Queue entry: sample, replace flag, ring slot, count after this sample
    assign q_data = {sample, full_ring, slot, held};

    // Fill level and overwrite pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            wp_reg   <= '0;
        end
        else if (q_push)
        begin
            fill_reg <= fill_next;
            wp_reg   <= wp_next;
        end
    end

endmodule

// ===== sv/wma_fifo.sv =====
module wma_fifo #(
    parameter int WIDTH = 46
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    import wma_pkg::*;

    logic [WIDTH-1:0] entry_reg [0:1];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== sv/wma_back.sv =====
module wma_back #(
    parameter int WINDOW = 64,
    parameter int CW     = 7,
    parameter int AW     = 6,
    parameter int IW     = 46
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  logic [IW-1:0]                   q_data,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [wma_pkg::AVG_W-1:0]       average,
    output logic [wma_pkg::HELD_W-1:0]      held_count
);
    import wma_pkg::*;

    localparam int SW  = SAMPLE_W + CW;
    localparam int STW = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [SAMPLE_W-1:0]   ring [0:WINDOW-1];
    logic [SAMPLE_W-1:0]   old_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic                  replace_reg;
    logic [CW-1:0]         count_reg;
    logic [SW-1:0]         sum_reg;
    logic [SW-1:0]         sum_next;
    logic [CW-1:0]         rem_reg;
    logic [CW-1:0]         rem_next;
    logic [AVG_W-1:0]      dq_reg;
    logic [STW-1:0]        step_reg;
    logic                  out_valid_reg;
    logic [AVG_W-1:0]      average_reg;
    logic [HELD_W-1:0]     held_reg;

    logic [SAMPLE_W-1:0]   head_sample;
    logic                  head_replace;
    logic [AW-1:0]         head_slot;
    logic [CW-1:0]         head_count;
    logic [CW:0]           trial;
    logic [CW:0]           diff;
    logic                  take;
    logic                  load_out;

    // Unpack the queue head
    assign head_count   = q_data[CW-1:0];
    assign head_slot    = q_data[CW +: AW];
    assign head_replace = q_data[CW + AW];
    assign head_sample  = q_data[IW-1 -: SAMPLE_W];

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    // Result register free: empty, or its transaction completes this edge
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Ring memory: old entry read out as the new one is written
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            old_reg          <= ring[head_slot];
            ring[head_slot]  <= head_sample;
        end
    end

    // Running sum update: add new sample, drop the overwritten one
    always_comb
    begin
        sum_next = sum_reg + SW'(sample_reg);
        if (replace_reg)
        begin
            sum_next = sum_next - SW'(old_reg);
        end
    end

    // One restoring divide step: next quotient bit
    always_comb
    begin
        trial = {rem_reg, dq_reg[AVG_W-1]};
        diff  = trial - {1'b0, count_reg};
        take  = (trial >= {1'b0, count_reg});
        if (take)
        begin
            rem_next = diff[CW-1:0];
        end
        else
        begin
            rem_next = trial[CW-1:0];
        end
    end

    // Sequencer: fetch, sum, divide, deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            sample_reg    <= '0;
            replace_reg   <= 1'b0;
            count_reg     <= '0;
            rem_reg       <= '0;
            dq_reg        <= '0;
            average_reg   <= '0;
            held_reg      <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        sample_reg  <= head_sample;
                        replace_reg <= head_replace;
                        count_reg   <= head_count;
                        state_reg   <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    // sum < count * 2^32, so the upper part is below count
                    sum_reg   <= sum_next;
                    rem_reg   <= sum_next[SW-1:AVG_W];
                    dq_reg    <= sum_next[AVG_W-1:0];
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_next;
                    dq_reg   <= {dq_reg[AVG_W-2:0], take};
                    step_reg <= step_reg + STW'(1);
                    if (step_reg == STW'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        average_reg <= dq_reg;
                        held_reg    <= HELD_W'(count_reg);
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign average    = average_reg;
    assign held_count = held_reg;

endmodule

// ===== sv/windowed_moving_average.sv =====
// Moving average of the last WINDOW unsigned 32-bit duration samples.
// Input channel: sample with in_valid / in_stall; a transaction happens at a
// clock edge with in_valid high and in_stall low. Each sample gives exactly
// one result transaction on average / held_count with out_valid / out_stall:
// the truncated mean of the samples held (this one included) and how many
// samples are held, 1 up to WINDOW (reported modulo 128).
// The front end classifies a sample (append or overwrite oldest slot) and
// queues it in a two-entry queue; the back end updates the ring and running
// sum, then runs a 32-step restoring divider, one quotient bit per cycle.
// The back end works on one sample at a time, in order: fetch, sum, 32
// divide steps and the result load, and fetches the next only after that.
// in_stall rises when the queue holds two samples waiting for the back end.
// While out_stall holds a result, the next result waits finished in the back
// end and the queue keeps taking samples until full.
// Reset (rst_n low, asynchronous) empties the window, the queue and the
// output register; ring contents are not cleared and need no clearing pass.
module windowed_moving_average #(
    parameter int WINDOW = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [wma_pkg::SAMPLE_W-1:0]    sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [wma_pkg::AVG_W-1:0]       average,
    output logic [wma_pkg::HELD_W-1:0]      held_count
);
    import wma_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);
    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IW = SAMPLE_W + 1 + AW + CW;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [IW-1:0] q_in;
    logic [IW-1:0] q_out;

    wma_front #(
        .WINDOW (WINDOW),
        .CW     (CW),
        .AW     (AW),
        .IW     (IW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    wma_fifo #(
        .WIDTH (IW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    wma_back #(
        .WINDOW (WINDOW),
        .CW     (CW),
        .AW     (AW),
        .IW     (IW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .average    (average),
        .held_count (held_count)
    );

endmodule

// ===== bench/windowed_moving_average_tb.sv =====
module windowed_moving_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wma_pkg::*;

    localparam int WINDOW       = 64;
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW);
    localparam int N_DIRECTED   = 14;
    localparam int N_RANDOM     = 1336;
    localparam int HOLD_AT      = 400;   // random samples sent before the long output hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 800;   // random samples sent before the sender drains the block
    localparam int QUIET_AT     = 1050;  // from here on neither side idles
    localparam int TAIL_CYCLES  = 60;
    localparam int STUCK_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [AVG_W-1:0]  average;
        logic [HELD_W-1:0] held;
    } mean_result_t;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        bit                  typed;
        logic [AVG_W-1:0]    average;
        logic [HELD_W-1:0]   held;
    } sample_row_t;

    typedef enum int {
        SEG_FULL_RANGE,
        SEG_ALL_MAX,
        SEG_ALL_ZERO,
        SEG_SMALL,
        SEG_EXTREMES
    } segment_kind_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample;
    logic                out_valid;
    logic                out_stall;
    logic [AVG_W-1:0]    average;
    logic [HELD_W-1:0]   held_count;

    // Window predictor state
    logic [SAMPLE_W-1:0] window_copy [WINDOW];
    int unsigned         oldest_slot;
    int unsigned         held_now;
    logic [SUM_W-1:0]    window_sum;

    mean_result_t        expected_means[$];
    sample_row_t         sample_table [N_DIRECTED];

    bit                  idle_enable;
    bit                  long_hold_req;
    int unsigned         samples_sent;
    int unsigned         means_checked;
    int unsigned         overwrites;
    int unsigned         input_stall_cycles;
    int unsigned         mismatches;
    int unsigned         stuck_cycles;

    windowed_moving_average #(
        .WINDOW(WINDOW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .average   (average),
        .held_count(held_count)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Add one sample to the window and return the mean that should follow
    function automatic mean_result_t advance_window(input logic [SAMPLE_W-1:0] s);
        mean_result_t r;
        if (held_now >= WINDOW)
        begin
            // full: drop the oldest sample, store the new one in its slot
            window_sum = window_sum - SUM_W'(window_copy[oldest_slot]) + SUM_W'(s);
            window_copy[oldest_slot] = s;
            oldest_slot = (oldest_slot + 1) % WINDOW;
            overwrites++;
        end
        else
        begin
            window_copy[held_now] = s;
            held_now++;
            window_sum = window_sum + SUM_W'(s);
        end
        r.average = AVG_W'(window_sum / SUM_W'(held_now));
        r.held    = HELD_W'(held_now);
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input segment_kind_t kind);
        logic [SAMPLE_W-1:0] v;
        case (kind)
            SEG_ALL_MAX:  v = '1;
            SEG_ALL_ZERO: v = '0;
            SEG_SMALL:    v = SAMPLE_W'($urandom_range(0, 1000));
            SEG_EXTREMES:
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = SAMPLE_W'(1);
                    2:       v = '1;
                    3:       v = {1'b0, {(SAMPLE_W-1){1'b1}}};
                    default: v = {1'b1, {(SAMPLE_W-1){1'b0}}};
                endcase
            default:      v = SAMPLE_W'($urandom());
        endcase
        return v;
    endfunction

    function automatic sample_row_t row(input logic [SAMPLE_W-1:0] value, input bit typed,
                                        input logic [AVG_W-1:0] avg, input int held);
        sample_row_t r;
        r.value   = value;
        r.typed   = typed;
        r.average = avg;
        r.held    = HELD_W'(held);
        return r;
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Offer one sample, hold it until the block takes it, then predict its mean.
    // Called at a rising edge; returns at the edge that accepted the transaction.
    task automatic send_sample(input sample_row_t r);
        mean_result_t want;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= r.value;
        do
            @(posedge clk);
        while (in_stall);
        want = advance_window(r.value);
        if (r.typed)
        begin
            want.average = r.average;
            want.held    = r.held;
        end
        expected_means.insert(expected_means.size(), want);
        samples_sent++;
    endtask

    // Stimulus
    initial
    begin
        segment_kind_t kind;
        int            seg_len;
        int            sent_random;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample        = '0;
        idle_enable   = 1'b1;
        long_hold_req = 1'b0;
        samples_sent  = 0;
        overwrites    = 0;
        held_now      = 0;
        oldest_slot   = 0;
        window_sum    = '0;
        sent_random   = 0;

        // First rows start from an empty window, so their means follow by hand
        sample_table = '{
            row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1),
            row(32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 2),
            row(32'hFFFF_FFFF, 1'b1, 32'hAAAA_AAAA, 3),
            row(32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 4),
            row(32'hAAAA_AAAA, 1'b0, '0, 0),
            row(32'h5555_5555, 1'b0, '0, 0),
            row(32'h0000_0001, 1'b0, '0, 0),
            row(32'h8000_0000, 1'b0, '0, 0),
            row(32'h7FFF_FFFF, 1'b0, '0, 0),
            row(32'h0000_0002, 1'b0, '0, 0),
            row(32'hFFFF_FFFE, 1'b0, '0, 0),
            row(32'hDEAD_BEEF, 1'b0, '0, 0),
            row(32'h0000_FFFF, 1'b0, '0, 0),
            row(32'hFFFF_0000, 1'b0, '0, 0)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        for (int i = 0; i < N_DIRECTED; i++)
            send_sample(sample_table[i]);

        // Random segments; long all-max runs saturate the full window
        while (sent_random < N_RANDOM)
        begin
            kind    = segment_kind_t'($urandom_range(0, 4));
            seg_len = (kind == SEG_ALL_MAX) ? $urandom_range(WINDOW, WINDOW + 36)
                                            : $urandom_range(1, 80);
            for (int k = 0; k < seg_len && sent_random < N_RANDOM; k++)
            begin
                if (sent_random == HOLD_AT)
                    long_hold_req = 1'b1;
                if (sent_random == QUIET_AT)
                    idle_enable = 1'b0;
                if (sent_random == DRAIN_AT)
                begin
                    // sender pause until the block has handed back everything
                    in_valid <= 1'b0;
                    while (expected_means.size() != 0)
                        @(posedge clk);
                end
                send_sample(row(pick_sample(kind), 1'b0, '0, 0));
                sent_random++;
            end
        end
        in_valid <= 1'b0;

        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d samples, checked %0d means; window wrapped through %0d overwrites.",
                 samples_sent, means_checked, overwrites);
        $display("Input stalled for %0d cycles, %0d mismatches.",
                 input_stall_cycles, mismatches);
        if (mismatches == 0)
            $display("** windowed_moving_average: PASSED **");
        else
            $display("** windowed_moving_average: FAILED **");
        $finish;
    end

    // Output stall: random bursts, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall     <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (idle_enable && rst_n && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each result transaction with the oldest expected mean
    initial means_checked = 0;
    initial mismatches = 0;
    always @(posedge clk)
    begin : check_means
        mean_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_means.size() == 0)
                note_mismatch($sformatf("unexpected result average=%h held_count=%0d",
                                        average, held_count));
            else
            begin
                want = expected_means.pop_front();
                means_checked++;
                if (average !== want.average)
                    note_mismatch($sformatf("average: expected %h, got %h",
                                            want.average, average));
                if (held_count !== want.held)
                    note_mismatch($sformatf("held_count: expected %0d, got %0d",
                                            want.held, held_count));
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    initial stuck_cycles = 0;
    initial input_stall_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            input_stall_cycles++;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles, %0d means outstanding.",
                     stuck_cycles, expected_means.size());
            $display("** windowed_moving_average: FAILED **");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
sv/wma_pkg.sv
sv/wma_front.sv
sv/wma_fifo.sv
sv/wma_back.sv
sv/windowed_moving_average.sv
bench/windowed_moving_average_tb.sv
